// ===== design/bba_pkg.sv =====
// ----------------------------------------------------------------------------
// bba_pkg
// types and constants shared by the bitmap block allocator
// ----------------------------------------------------------------------------
package bba_pkg;

    localparam logic [31:0] FULL_WORD = 32'hFFFF_FFFF;

    typedef enum logic [1:0] {
        CMD_INIT  = 2'd0,
        CMD_USED  = 2'd1,
        CMD_FREE  = 2'd2,
        CMD_ALLOC = 2'd3
    } t_cmd;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_INIT,
        ST_MRD,
        ST_MWR,
        ST_SRD,
        ST_SCAN,
        ST_DONE
    } t_state;

endpackage

// ===== design/bba_ram.sv =====
// ----------------------------------------------------------------------------
// bba_ram
// generic single port ram, registered read
// ----------------------------------------------------------------------------
module bba_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end

endmodule

// ===== design/bitmap_block_allocator_top.sv =====
// ----------------------------------------------------------------------------
// bitmap_block_allocator_top
// first-fit block allocator over a used/free bitmap held in one ram
// ----------------------------------------------------------------------------
// channel   direction  ports
// command   in         i_start, o_busy, i_command, i_block_index, i_block_count
// result    out        o_done, o_start_block, o_failed, o_used_count
// config    in         i_cfg_we, i_cfg_data (max_blocks)
//
// init writes every bitmap word, one word per cycle.
// mark reads, then writes back, each word touched, capped at the bitmap end;
// allocate reads, then checks, each word scanned up to min(max_blocks,
// NUM_BLOCKS)/32 words, then marks the run as a mark-used command.
// every item ends with one result cycle.
// reset behaves as an init pass; busy stays high meanwhile.
// the result strobe o_done lasts one cycle and cannot be held off.
// ----------------------------------------------------------------------------
module bitmap_block_allocator_top #(
    parameter int NUM_BLOCKS = 32768
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    output logic        o_busy,
    input  logic [1:0]  i_command,
    input  logic [14:0] i_block_index,
    input  logic [15:0] i_block_count,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_data,
    output logic        o_done,
    output logic [14:0] o_start_block,
    output logic        o_failed,
    output logic [15:0] o_used_count
);

    localparam int WORDS = (NUM_BLOCKS + 31) / 32;
    localparam int AW    = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int BW    = AW + 5;   // block address width
    localparam int CW    = 21;       // wide enough for NUM_BLOCKS and counts
    localparam logic [CW-1:0] NB = CW'(NUM_BLOCKS);

    bba_pkg::t_state r_state, n_state;
    logic [15:0]   r_max;
    logic [CW-1:0] r_used, n_used;
    logic [AW-1:0] r_addr, n_addr;
    logic [CW-1:0] r_pos, n_pos;      // current block of a mark
    logic [CW-1:0] r_left, n_left;    // blocks still to mark
    logic          r_set, n_set;
    logic [CW-1:0] r_want, n_want;
    logic [CW-1:0] r_run, n_run;      // free blocks carried into the next word
    logic [BW-1:0] r_rstart, n_rstart;
    logic [AW:0]   r_words, n_words;
    logic [14:0]   r_sb, n_sb;
    logic          r_fail, n_fail;

    logic          we;
    logic [31:0]   wdata, rdata;
    logic [AW-1:0] addr;

    bba_ram #(.WIDTH(32), .DEPTH(WORDS)) u_ram (
        .i_clk  (i_clk),
        .i_we   (we),
        .i_addr (addr),
        .i_wdata(wdata),
        .o_rdata(rdata)
    );

    // mark work inside one word
    logic [4:0]    bit_lo;
    logic [5:0]    room;
    logic [CW-1:0] nmark;
    logic [31:0]   mmask;
    logic [CW-1:0] cap;
    logic [CW-1:0] mark_cnt;

    always_comb begin
        bit_lo = r_pos[4:0];
        room   = 6'd32 - {1'b0, bit_lo};
        nmark  = (r_left < CW'(room)) ? r_left : CW'(room);
        // nmark ones from the msb, then moved down to the first block
        mmask  = 32'({bba_pkg::FULL_WORD, 32'd0} >> nmark[5:0]) >> bit_lo;
    end

    // count update for nmark blocks, saturating each step
    logic [CW-1:0] mx;
    always_comb begin
        mx = {5'd0, r_max};
        if (r_set) begin
            if (r_used >= mx)      cap = r_used;
            else if (mx - r_used < nmark) cap = mx;
            else                   cap = r_used + nmark;
        end else begin
            if (r_used < nmark)    cap = '0;
            else                   cap = r_used - nmark;
        end
    end

    // scan of one word, msb first: a run carried in from earlier words is
    // checked against the leading free bits, runs inside the word by windows
    logic [5:0]    lead_free;
    logic [5:0]    trail_free;
    logic [31:0]   wmask;
    logic          w_hit;
    logic [4:0]    w_at;
    logic          c_hit;
    logic [CW-1:0] s_run;
    logic [BW-1:0] s_start;
    logic          s_hit;
    logic [BW-1:0] s_hit_at;
    always_comb begin
        lead_free  = 6'd32;
        trail_free = 6'd32;
        for (int j = 0; j < 32; j++) begin
            if (rdata[j]) lead_free = 6'(31 - j);
        end
        for (int j = 31; j >= 0; j--) begin
            if (rdata[j]) trail_free = 6'(j);
        end
        wmask = 32'({bba_pkg::FULL_WORD, 32'd0} >> r_want[5:0]);
        w_hit = 1'b0;
        w_at  = '0;
        // lowest window of r_want free blocks wins
        for (int p = 31; p >= 0; p--) begin
            if (r_want <= CW'(32 - p) && ((rdata << p) & wmask) == '0) begin
                w_hit = 1'b1;
                w_at  = 5'(p);
            end
        end
        c_hit    = (r_run != '0) && (r_run + CW'(lead_free) >= r_want);
        s_hit    = c_hit || w_hit;
        s_hit_at = c_hit ? r_rstart : {r_addr, w_at};
        if (lead_free == 6'd32) begin
            s_run   = r_run + CW'(6'd32);
            s_start = (r_run == '0) ? {r_addr, 5'd0} : r_rstart;
        end else begin
            s_run   = CW'(trail_free);
            s_start = {r_addr, 5'(6'd32 - trail_free)};
        end
    end

    logic [CW-1:0] lim;
    always_comb begin
        lim = ({5'd0, r_max} > NB) ? NB : {5'd0, r_max};
    end

    always_comb begin
        mark_cnt = {5'd0, i_block_count};
    end

    // next state
    always_comb begin
        n_state  = r_state;
        n_used   = r_used;
        n_addr   = r_addr;
        n_pos    = r_pos;
        n_left   = r_left;
        n_set    = r_set;
        n_want   = r_want;
        n_run    = r_run;
        n_rstart = r_rstart;
        n_words  = r_words;
        n_sb     = r_sb;
        n_fail   = r_fail;
        case (r_state)
            bba_pkg::ST_IDLE: begin
                if (i_start) begin
                    n_sb   = '0;
                    n_fail = 1'b0;
                    n_set  = 1'b1;
                    case (bba_pkg::t_cmd'(i_command))
                        bba_pkg::CMD_INIT: begin
                            n_addr  = '0;
                            n_used  = {5'd0, r_max};
                            n_state = bba_pkg::ST_INIT;
                        end
                        bba_pkg::CMD_USED, bba_pkg::CMD_FREE: begin
                            n_set = (bba_pkg::t_cmd'(i_command) == bba_pkg::CMD_USED);
                            n_pos = {6'd0, i_block_index};
                            // clip to bitmap end
                            if ({6'd0, i_block_index} >= NB) n_left = '0;
                            else if (NB - {6'd0, i_block_index} < mark_cnt)
                                n_left = NB - {6'd0, i_block_index};
                            else n_left = mark_cnt;
                            n_addr  = AW'(i_block_index >> 5);
                            n_state = (n_left == '0) ? bba_pkg::ST_DONE : bba_pkg::ST_MRD;
                        end
                        default: begin
                            n_want  = mark_cnt;
                            n_run   = '0;
                            n_addr  = '0;
                            n_words = (AW+1)'(lim >> 5);
                            if (mark_cnt == '0 || (lim >> 5) == '0) begin
                                n_fail  = 1'b1;
                                n_state = bba_pkg::ST_DONE;
                            end else begin
                                n_state = bba_pkg::ST_SRD;
                            end
                        end
                    endcase
                end
            end
            bba_pkg::ST_INIT: begin
                n_addr = r_addr + 1'b1;
                if (r_addr == AW'(WORDS - 1)) n_state = bba_pkg::ST_DONE;
            end
            bba_pkg::ST_MRD: begin
                n_state = bba_pkg::ST_MWR;
            end
            bba_pkg::ST_MWR: begin
                n_used = cap;
                n_pos  = r_pos + nmark;
                n_left = r_left - nmark;
                n_addr = r_addr + 1'b1;
                n_state = (r_left == nmark) ? bba_pkg::ST_DONE : bba_pkg::ST_MRD;
            end
            bba_pkg::ST_SRD: begin
                n_state = bba_pkg::ST_SCAN;
            end
            bba_pkg::ST_SCAN: begin
                n_run    = s_run;
                n_rstart = s_start;
                if (s_hit) begin
                    n_sb    = 15'(s_hit_at);
                    n_pos   = CW'(s_hit_at);
                    n_left  = r_want;
                    n_set   = 1'b1;
                    n_addr  = AW'(s_hit_at >> 5);
                    n_state = bba_pkg::ST_MRD;
                end else if ({1'b0, r_addr} + 1'b1 == r_words) begin
                    n_fail  = 1'b1;
                    n_state = bba_pkg::ST_DONE;
                end else begin
                    n_addr  = r_addr + 1'b1;
                    n_state = bba_pkg::ST_SRD;
                end
            end
            default: begin
                n_state = bba_pkg::ST_IDLE;
            end
        endcase
    end

    // outputs
    always_comb begin
        addr  = r_addr;
        we    = 1'b0;
        wdata = rdata;
        case (r_state)
            bba_pkg::ST_INIT: begin
                we    = 1'b1;
                wdata = bba_pkg::FULL_WORD;
            end
            bba_pkg::ST_MWR: begin
                we    = 1'b1;
                wdata = r_set ? (rdata | mmask) : (rdata & ~mmask);
            end
            default: begin
                we = 1'b0;
            end
        endcase
        o_busy        = (r_state != bba_pkg::ST_IDLE);
        o_done        = (r_state == bba_pkg::ST_DONE);
        o_start_block = r_sb;
        o_failed      = r_fail;
        o_used_count  = r_used[15:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= bba_pkg::ST_INIT;
            r_max   <= 16'd32768;
            r_used  <= NB;
            r_addr  <= '0;
            r_set   <= 1'b1;
            r_sb    <= '0;
            r_fail  <= 1'b0;
        end else begin
            // the reset init pass ends without a result strobe
            r_state <= (r_state == bba_pkg::ST_INIT && n_state == bba_pkg::ST_DONE
                        && r_set && r_pos == '1) ? bba_pkg::ST_IDLE : n_state;
            if (i_cfg_we) r_max <= i_cfg_data;
            r_used  <= n_used;
            r_addr  <= n_addr;
            r_set   <= n_set;
            r_sb    <= n_sb;
            r_fail  <= n_fail;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '1;
        end else begin
            r_pos <= (r_state == bba_pkg::ST_INIT && r_pos == '1 && n_state == bba_pkg::ST_DONE)
                     ? '0 : n_pos;
        end
        r_left   <= n_left;
        r_want   <= n_want;
        r_run    <= n_run;
        r_rstart <= n_rstart;
        r_words  <= n_words;
    end

endmodule

// ===== dv/tb_bitmap_block_allocator_top.sv =====
// ----------------------------------------------------------------------------
// tb_bitmap_block_allocator_top
// self-checking bench: a bit-level bitmap predictor computes each item's
// result at acceptance; the monitor compares every done strobe in order
// ----------------------------------------------------------------------------
module tb_bitmap_block_allocator_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NBLK = 32768;

    typedef struct {
        bba_pkg::t_cmd cmd;
        logic [14:0]   index;
        logic [15:0]   count;
    } t_item;

    typedef struct {
        logic [14:0] start_block;
        logic        failed;
        logic [15:0] used_count;
    } t_outcome;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_start = 1'b0;
    logic        o_busy;
    logic [1:0]  i_command = 2'd0;
    logic [14:0] i_block_index = '0;
    logic [15:0] i_block_count = '0;
    logic        i_cfg_we = 1'b0;
    logic [15:0] i_cfg_data = '0;
    logic        o_done;
    logic [14:0] o_start_block;
    logic        o_failed;
    logic [15:0] o_used_count;

    bitmap_block_allocator_top #(.NUM_BLOCKS(NBLK)) dut (.*);

    // predictor state
    bit          used_map [NBLK];
    int unsigned used_total;
    int unsigned max_blocks;

    t_item    pending_items [$];
    t_outcome expected_results [$];
    int  launched = 0;
    int  accepted = 0;
    int  errors = 0;
    int  gap = 0;
    bit  rst_done = 0;
    bit  quiet = 0;

    initial forever #5 i_clk = ~i_clk;

    task automatic report_mismatch(input string what, input int got, input int want);
        errors++;
        $display("[%0t] mismatch %s: got %0d expected %0d", $realtime, what, got, want);
    endtask

    function automatic void mark_blocks(int unsigned first, int unsigned cnt, bit val);
        int unsigned b;
        for (int unsigned k = 0; k < cnt; k++) begin
            b = first + k;
            if (b >= NBLK) break;
            used_map[b] = val;
            if (val) begin
                if (used_total < max_blocks) used_total++;
            end else if (used_total > 0) begin
                used_total--;
            end
        end
    endfunction

    // first fit over whole words below the limit; an all-used word breaks a run
    function automatic bit find_run(int unsigned want, output int unsigned start);
        int unsigned limit, words, left, run_start;
        bit full;
        start = 0;
        run_start = 0;
        if (want == 0) return 0;
        limit = (max_blocks > NBLK) ? NBLK : max_blocks;
        words = limit / 32;
        left = want;
        for (int unsigned w = 0; w < words; w++) begin
            full = 1;
            for (int j = 0; j < 32; j++) if (!used_map[w*32+j]) full = 0;
            if (full) begin
                left = want;
                continue;
            end
            for (int unsigned j = 0; j < 32; j++) begin
                if (!used_map[w*32+j]) begin
                    if (left == want) run_start = w*32 + j;
                    left--;
                    if (left == 0) begin
                        start = run_start;
                        return 1;
                    end
                end else begin
                    left = want;
                end
            end
        end
        return 0;
    endfunction

    function automatic t_outcome predict_outcome(t_item it);
        t_outcome r;
        int unsigned s;
        r.start_block = '0;
        r.failed = 1'b0;
        case (it.cmd)
            bba_pkg::CMD_INIT: begin
                foreach (used_map[b]) used_map[b] = 1;
                used_total = max_blocks;
            end
            bba_pkg::CMD_USED: mark_blocks(it.index, it.count, 1);
            bba_pkg::CMD_FREE: mark_blocks(it.index, it.count, 0);
            default: begin
                if (find_run(it.count, s)) begin
                    mark_blocks(s, it.count, 1);
                    r.start_block = s[14:0];
                end else begin
                    r.failed = 1'b1;
                end
            end
        endcase
        r.used_count = used_total[15:0];
        return r;
    endfunction

    // driver: start stays high until the handshake completes
    always @(negedge i_clk) begin
        t_item it;
        if (!rst_done) begin
            i_start <= 1'b0;
        end else if (i_start && launched != accepted) begin
            i_start <= 1'b1;
        end else if (gap > 0) begin
            gap--;
            i_start <= 1'b0;
        end else if (pending_items.size() > 0) begin
            it = pending_items.pop_front();
            i_command <= it.cmd;
            i_block_index <= it.index;
            i_block_count <= it.count;
            i_start <= 1'b1;
            launched++;
            if (!quiet && $urandom_range(0, 5) == 0) gap = $urandom_range(1, 7);
        end else begin
            i_start <= 1'b0;
        end
    end

    // monitor: check results, then predict for a newly accepted item
    always @(posedge i_clk) begin
        t_outcome want;
        t_item it;
        if (i_rst_n) begin
            if (o_done) begin
                if (expected_results.size() == 0) begin
                    report_mismatch("unexpected result", 1, 0);
                end else begin
                    want = expected_results.pop_front();
                    if (o_start_block !== want.start_block)
                        report_mismatch("start_block", o_start_block, want.start_block);
                    if (o_failed !== want.failed)
                        report_mismatch("failed", o_failed, want.failed);
                    if (o_used_count !== want.used_count)
                        report_mismatch("used_count", o_used_count, want.used_count);
                end
            end
            if (i_start && !o_busy) begin
                it.cmd = bba_pkg::t_cmd'(i_command);
                it.index = i_block_index;
                it.count = i_block_count;
                expected_results.push_back(predict_outcome(it));
                accepted++;
            end
        end
    end

    task automatic push_item(bba_pkg::t_cmd c, int unsigned idx, int unsigned cnt);
        t_item it;
        it.cmd = c;
        it.index = idx[14:0];
        it.count = cnt[15:0];
        pending_items.push_back(it);
    endtask

    task automatic wait_idle();
        do @(posedge i_clk);
        while (pending_items.size() > 0 || launched != accepted ||
               expected_results.size() > 0 || o_busy);
    endtask

    task automatic write_max_blocks(int unsigned v);
        wait_idle();
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_data <= v[15:0];
        max_blocks = v;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic push_random_item(int unsigned window);
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 3) begin
            push_item(bba_pkg::CMD_INIT, $urandom, $urandom);
        end else if (r < 35) begin
            push_item(bba_pkg::CMD_FREE,
                      ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, window),
                      ($urandom_range(0, 15) == 0) ? $urandom : $urandom_range(1, 96));
        end else if (r < 48) begin
            push_item(bba_pkg::CMD_USED,
                      ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, window),
                      ($urandom_range(0, 20) == 0) ? $urandom : $urandom_range(0, 48));
        end else begin
            case ($urandom_range(0, 19))
                0:       push_item(bba_pkg::CMD_ALLOC, $urandom, 0);
                1:       push_item(bba_pkg::CMD_ALLOC, $urandom, $urandom);
                2, 3:    push_item(bba_pkg::CMD_ALLOC, $urandom, $urandom_range(33, 300));
                default: push_item(bba_pkg::CMD_ALLOC, $urandom, $urandom_range(1, 32));
            endcase
        end
    endtask

    initial begin
        int unsigned settings [6];
        foreach (used_map[b]) used_map[b] = 1;
        used_total = NBLK;
        max_blocks = 32768;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        rst_done = 1;

        // directed: fully used bitmap, zero counts, word edges, range past the end
        push_item(bba_pkg::CMD_ALLOC, 0, 1);
        push_item(bba_pkg::CMD_ALLOC, 0, 0);
        push_item(bba_pkg::CMD_USED, 5, 3);
        push_item(bba_pkg::CMD_FREE, 0, 0);
        push_item(bba_pkg::CMD_FREE, 31, 33);
        push_item(bba_pkg::CMD_ALLOC, 0, 33);
        push_item(bba_pkg::CMD_FREE, 60, 4);
        push_item(bba_pkg::CMD_FREE, 96, 5);
        push_item(bba_pkg::CMD_ALLOC, 0, 9);
        push_item(bba_pkg::CMD_ALLOC, 0, 4);
        push_item(bba_pkg::CMD_FREE, 32700, 200);
        push_item(bba_pkg::CMD_USED, 32760, 65535);
        push_item(bba_pkg::CMD_FREE, 32767, 1);
        push_item(bba_pkg::CMD_ALLOC, 0, 68);
        push_item(bba_pkg::CMD_FREE, 0, 65535);
        push_item(bba_pkg::CMD_ALLOC, 0, 65535);
        push_item(bba_pkg::CMD_ALLOC, 0, 32768);
        push_item(bba_pkg::CMD_USED, 0, 1);
        push_item(bba_pkg::CMD_FREE, 0, 2);
        push_item(bba_pkg::CMD_ALLOC, 0, 1);
        push_item(bba_pkg::CMD_INIT, 32767, 65535);
        push_item(bba_pkg::CMD_FREE, 32767, 1);

        settings = '{32, 65535, 4096, 0, 40, 32768};
        settings[3] = $urandom_range(33, 32767);
        foreach (settings[p]) begin
            write_max_blocks(settings[p]);
            if (p == 5) quiet = 1;
            // start each phase with free space so allocations go deep
            push_item(bba_pkg::CMD_FREE, 0, settings[p] > 32768 ? 32768 : settings[p]);
            for (int n = 0; n < 94; n++)
                push_random_item(settings[p] > 32767 ? 32767 : settings[p]);
        end

        wait_idle();
        repeat (50) @(posedge i_clk);
        if (errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    initial begin
        #200ms;
        $display("FAILURE");
        $finish;
    end

endmodule
